FILE: src/fbsc_pkg.sv
// Shared types and constants for the frustum box/sphere cull core.
package fbsc_pkg;

  localparam int PLANE_FIELD_W = 16;
  localparam int PLANE_REG_W   = 4 * PLANE_FIELD_W;
  localparam int REG_COUNT     = 6;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = PLANE_REG_W;
  localparam int RADIUS_W      = 15;
  localparam int VERDICT_W     = 2;
  localparam int AXES          = 3;
  localparam int CORNERS       = 8;

  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam verdict_t VERDICT_OUTSIDE      = 2'd0;
  localparam verdict_t VERDICT_INTERSECTING = 2'd1;
  localparam verdict_t VERDICT_INSIDE       = 2'd2;

  localparam logic FUNC_BOX    = 1'b0;
  localparam logic FUNC_SPHERE = 1'b1;

  typedef logic [PLANE_REG_W-1:0] plane_reg_t;

  // per-plane classification carried into the final reduction stage
  typedef struct packed {
    logic all_neg;     // box: every corner strictly behind the plane
    logic any_neg;     // box: at least one corner behind the plane
    logic s_inside;    // sphere: distance above radius
    logic s_outside;   // sphere: distance below -radius
  } plane_flags_t;

endpackage

FILE: src/fbsc_in_if.sv
// Input item channel: bounding volume to classify.
interface fbsc_in_if #(
  parameter int COORD_WIDTH = 16
);
  import fbsc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [RADIUS_W-1:0]    sphere_radius;

  modport source (
    output valid, func, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, center_x, center_y, center_z,
           sphere_radius,
    input  ready
  );

  modport sink (
    input  valid, func, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, center_x, center_y, center_z,
           sphere_radius,
    output ready
  );
endinterface

FILE: src/fbsc_out_if.sv
// Result item channel: cull verdict.
interface fbsc_out_if;
  import fbsc_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

FILE: src/frustum_box_sphere_cull_core.sv
// Frustum cull core: classifies a box or sphere against the plane registers.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    func, box min/max xyz, center xyz, sphere_radius
//   out_ch    out  valid/ready    verdict
//   cfg_*     in   cfg_we only    cfg_index selects plane, cfg_data packed plane
//
// One item per cycle sustained while out_ch accepts; out_ch.valid rises once an
// accepted item has passed the input register, multiplier bank, plane sums and
// compares, and verdict register. The pipeline advances as a whole whenever the
// result register is empty or being taken, so in_ch.ready follows out_ch.ready.
// Synchronous active-low reset clears the valid bits and the plane registers;
// in_ch.ready stays low while reset is held.
module frustum_box_sphere_cull_core #(
  parameter int PLANE_COUNT      = 6,
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fbsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fbsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  fbsc_in_if.sink                            in_ch,
  fbsc_out_if.source                         out_ch
);
  import fbsc_pkg::*;

  localparam int PW  = PLANE_FIELD_W + COORD_WIDTH;           // product width
  localparam int DW  = PLANE_FIELD_W + NORMAL_FRAC_BITS;      // scaled offset
  localparam int RW  = RADIUS_W + NORMAL_FRAC_BITS + 1;       // scaled radius
  localparam int MW1 = (PW > DW) ? PW : DW;
  localparam int MW  = (MW1 > RW) ? MW1 : RW;
  localparam int SW  = MW + 2;                                // four-term sum

  // ---------------- plane registers ----------------
  plane_reg_t plane_r [REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) plane_r[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_INDEX_W'(REG_COUNT))) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // planes without a register read as zero
  plane_reg_t plane_w [PLANE_COUNT];

  for (genvar gp = 0; gp < PLANE_COUNT; gp++) begin : g_plane_sel
    if (gp < REG_COUNT) begin : g_reg
      assign plane_w[gp] = plane_r[gp];
    end else begin : g_zero
      assign plane_w[gp] = '0;
    end
  end

  // ---------------- pipeline control ----------------
  logic     advance;
  logic     s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  verdict_t out_verdict_r;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance && rst_n;
  assign out_ch.valid = out_valid_r;
  assign out_ch.verdict = out_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // ---------------- stage 1: input register ----------------
  // a sphere reuses the box datapath with both corners at the center
  logic                          s1_sphere_r;
  logic signed [COORD_WIDTH-1:0] s1_lo_r [AXES];
  logic signed [COORD_WIDTH-1:0] s1_hi_r [AXES];
  logic        [RADIUS_W-1:0]    s1_rad_r;
  logic signed [COORD_WIDTH-1:0] lo_nxt  [AXES];
  logic signed [COORD_WIDTH-1:0] hi_nxt  [AXES];

  always_comb begin
    if (in_ch.func == FUNC_SPHERE) begin
      lo_nxt[0] = in_ch.center_x;
      lo_nxt[1] = in_ch.center_y;
      lo_nxt[2] = in_ch.center_z;
      hi_nxt[0] = in_ch.center_x;
      hi_nxt[1] = in_ch.center_y;
      hi_nxt[2] = in_ch.center_z;
    end else begin
      lo_nxt[0] = in_ch.box_min_x;
      lo_nxt[1] = in_ch.box_min_y;
      lo_nxt[2] = in_ch.box_min_z;
      hi_nxt[0] = in_ch.box_max_x;
      hi_nxt[1] = in_ch.box_max_y;
      hi_nxt[2] = in_ch.box_max_z;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sphere_r <= (in_ch.func == FUNC_SPHERE);
      s1_rad_r    <= in_ch.sphere_radius;
      for (int a = 0; a < AXES; a++) begin
        s1_lo_r[a] <= lo_nxt[a];
        s1_hi_r[a] <= hi_nxt[a];
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic                 s2_sphere_r;
  logic signed [SW-1:0] s2_rad_r;
  logic signed [PW-1:0] s2_plo_r  [PLANE_COUNT][AXES];
  logic signed [PW-1:0] s2_phi_r  [PLANE_COUNT][AXES];
  logic signed [SW-1:0] s2_doff_r [PLANE_COUNT];
  logic signed [PW-1:0] plo_nxt   [PLANE_COUNT][AXES];
  logic signed [PW-1:0] phi_nxt   [PLANE_COUNT][AXES];
  logic signed [SW-1:0] doff_nxt  [PLANE_COUNT];

  always_comb begin
    logic signed [PLANE_FIELD_W-1:0] nrm;
    logic signed [PLANE_FIELD_W-1:0] dval;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int a = 0; a < AXES; a++) begin
        nrm = plane_w[p][a*PLANE_FIELD_W +: PLANE_FIELD_W];
        plo_nxt[p][a] = PW'(nrm) * PW'(s1_lo_r[a]);
        phi_nxt[p][a] = PW'(nrm) * PW'(s1_hi_r[a]);
      end
      dval = plane_w[p][AXES*PLANE_FIELD_W +: PLANE_FIELD_W];
      doff_nxt[p] = SW'(dval) <<< NORMAL_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sphere_r <= s1_sphere_r;
      s2_rad_r    <= $signed(SW'(s1_rad_r)) <<< NORMAL_FRAC_BITS;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        s2_doff_r[p] <= doff_nxt[p];
        for (int a = 0; a < AXES; a++) begin
          s2_plo_r[p][a] <= plo_nxt[p][a];
          s2_phi_r[p][a] <= phi_nxt[p][a];
        end
      end
    end
  end

  // ---------------- stage 3: corner sums and compares ----------------
  logic         s3_sphere_r;
  plane_flags_t s3_flags_r [PLANE_COUNT];
  plane_flags_t flags_nxt  [PLANE_COUNT];

  always_comb begin
    logic signed [SW-1:0] dist_sum;
    logic [CORNERS-1:0]   neg;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int c = 0; c < CORNERS; c++) begin
        dist_sum = (c[0] ? SW'(s2_phi_r[p][0]) : SW'(s2_plo_r[p][0]))
                 + (c[1] ? SW'(s2_phi_r[p][1]) : SW'(s2_plo_r[p][1]))
                 + (c[2] ? SW'(s2_phi_r[p][2]) : SW'(s2_plo_r[p][2]))
                 + s2_doff_r[p];
        neg[c] = dist_sum[SW-1];
      end
      // every corner equals the center for a sphere; corner 0 serves
      dist_sum = SW'(s2_plo_r[p][0]) + SW'(s2_plo_r[p][1]) + SW'(s2_plo_r[p][2])
               + s2_doff_r[p];
      flags_nxt[p].all_neg   = &neg;
      flags_nxt[p].any_neg   = |neg;
      flags_nxt[p].s_inside  = (dist_sum > s2_rad_r);
      flags_nxt[p].s_outside = (dist_sum < -s2_rad_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sphere_r <= s2_sphere_r;
      for (int p = 0; p < PLANE_COUNT; p++) s3_flags_r[p] <= flags_nxt[p];
    end
  end

  // ---------------- stage 4: verdict ----------------
  verdict_t verdict_nxt;

  always_comb begin
    logic culled_box, any_neg, culled_sph, all_in;
    culled_box = 1'b0;
    any_neg    = 1'b0;
    culled_sph = 1'b0;
    all_in     = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      culled_box = culled_box | s3_flags_r[p].all_neg;
      any_neg    = any_neg    | s3_flags_r[p].any_neg;
      culled_sph = culled_sph | s3_flags_r[p].s_outside;
      all_in     = all_in     & s3_flags_r[p].s_inside;
    end
    if (s3_sphere_r) begin
      verdict_nxt = culled_sph ? VERDICT_OUTSIDE :
                    (all_in ? VERDICT_INSIDE : VERDICT_INTERSECTING);
    end else begin
      verdict_nxt = culled_box ? VERDICT_OUTSIDE :
                    (any_neg ? VERDICT_INTERSECTING : VERDICT_INSIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_verdict_r <= verdict_nxt;
    end
  end

endmodule
